@@ rtl/core/gob_pkg.sv @@
// ----------------------------------------------------------------------------
// gob_pkg
// Shared types, widths and the CORDIC angle table of the gradient
// orientation binner.
// ----------------------------------------------------------------------------
package gob_pkg;

    localparam int unsigned GRAD_WIDTH    = 16;
    localparam int unsigned ANGLE_BITS    = 16;
    localparam int unsigned CORDIC_STEPS  = 26;
    localparam int unsigned NUM_WIDTH     = 7;
    localparam int unsigned BIN_WIDTH     = 6;
    localparam int unsigned NUM_MAX       = 64;
    localparam int unsigned NUM_RESET     = 8;

    // normalized magnitude has its leading one at this bit
    localparam int unsigned NORM_MSB      = 39;
    localparam int unsigned MSB_WIDTH     = $clog2(GRAD_WIDTH);
    localparam int unsigned SHIFT_WIDTH   = $clog2(NORM_MSB + 1);
    localparam int unsigned XY_WIDTH      = NORM_MSB + 5;

    // angle accumulator in units of pi/2^31, right angle is 2^30
    localparam int unsigned ZC_WIDTH      = 31;
    localparam int unsigned Z_WIDTH       = ZC_WIDTH + 2;
    localparam int unsigned ROUND_SHIFT   = ZC_WIDTH - ANGLE_BITS;

    localparam int unsigned PROD_WIDTH    = ANGLE_BITS + NUM_WIDTH + 2;

    // capture, search, shift, cordic steps, round, multiply, output
    localparam int unsigned PIPE_LATENCY  = CORDIC_STEPS + 6;

    localparam logic [NUM_WIDTH-1:0] NUM_MAX_CODE   = NUM_WIDTH'(NUM_MAX);
    localparam logic [NUM_WIDTH-1:0] NUM_RESET_CODE = NUM_WIDTH'(NUM_RESET);

    localparam logic [ANGLE_BITS:0]   HALF_TURN    = {1'b1, {ANGLE_BITS{1'b0}}};
    localparam logic [ANGLE_BITS-1:0] QUARTER_TURN = {1'b1, {(ANGLE_BITS-1){1'b0}}};
    localparam logic signed [Z_WIDTH-1:0] Z_RIGHT_ANGLE =
        {{(Z_WIDTH-ZC_WIDTH+1){1'b0}}, {(ZC_WIDTH-1){1'b0}}} | (Z_WIDTH'(1) << (ZC_WIDTH - 1));
    localparam logic [ZC_WIDTH-1:0] ROUND_HALF = ZC_WIDTH'(1) << (ROUND_SHIFT - 1);

    typedef struct packed {
        logic signed [GRAD_WIDTH-1:0] grad_horizontal;
        logic signed [GRAD_WIDTH-1:0] grad_vertical;
    } pixel_t;

    typedef struct packed {
        logic [BIN_WIDTH-1:0] orientation_bin;
        logic                 zero_gradient;
    } result_t;

    typedef struct packed {
        logic gx_neg;
        logic gy_neg;
        logic ax_zero;
        logic ay_zero;
        logic zero;
    } meta_t;

    // atan(2^-i) in units of pi/2^31
    function automatic logic signed [Z_WIDTH-1:0] atan_step(input int idx);
        logic signed [Z_WIDTH-1:0] val;
        unique case (idx)
            0:       val = Z_WIDTH'(536870912);
            1:       val = Z_WIDTH'(316933406);
            2:       val = Z_WIDTH'(167458907);
            3:       val = Z_WIDTH'(85004756);
            4:       val = Z_WIDTH'(42667331);
            5:       val = Z_WIDTH'(21354465);
            6:       val = Z_WIDTH'(10679838);
            7:       val = Z_WIDTH'(5340245);
            8:       val = Z_WIDTH'(2670163);
            9:       val = Z_WIDTH'(1335087);
            10:      val = Z_WIDTH'(667544);
            11:      val = Z_WIDTH'(333772);
            12:      val = Z_WIDTH'(166886);
            13:      val = Z_WIDTH'(83443);
            14:      val = Z_WIDTH'(41722);
            15:      val = Z_WIDTH'(20861);
            16:      val = Z_WIDTH'(10430);
            17:      val = Z_WIDTH'(5215);
            18:      val = Z_WIDTH'(2608);
            19:      val = Z_WIDTH'(1304);
            20:      val = Z_WIDTH'(652);
            21:      val = Z_WIDTH'(326);
            22:      val = Z_WIDTH'(163);
            23:      val = Z_WIDTH'(81);
            24:      val = Z_WIDTH'(41);
            25:      val = Z_WIDTH'(20);
            default: val = '0;
        endcase
        return val;
    endfunction

endpackage

@@ rtl/core/gradient_orientation_binner.sv @@
// ----------------------------------------------------------------------------
// gradient_orientation_binner
// Quantizes the direction of a pixel gradient, folded to a half circle and
// shifted by half a sector, into num_orientations equal sectors.
// ----------------------------------------------------------------------------
// One pixel request is taken every clock: busy is high only in the first
// cycle after reset release. Each request gives one result on the result
// port, marked by done, in request order; the depth is set by the 26-stage
// CORDIC angle pipeline plus six stages for capture, normalization,
// rounding, the sector multiply and the output register. Results cannot be
// held off, so the receiver must take each one in its strobe cycle.
// num_orientations is written through cfg_wr_en / cfg_wr_data while no
// request is in flight; 0 acts as 1 and values above 64 act as 64.
module gradient_orientation_binner (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  gob_pkg::pixel_t                     pixel,
    output logic                                done,
    output gob_pkg::result_t                    result,
    input  logic                                cfg_wr_en,
    input  logic [gob_pkg::NUM_WIDTH-1:0]       cfg_wr_data
);

    localparam int unsigned GW    = gob_pkg::GRAD_WIDTH;
    localparam int unsigned AB    = gob_pkg::ANGLE_BITS;
    localparam int unsigned STEPS = gob_pkg::CORDIC_STEPS;
    localparam int unsigned XYW   = gob_pkg::XY_WIDTH;
    localparam int unsigned ZW    = gob_pkg::Z_WIDTH;
    localparam int unsigned ZCW   = gob_pkg::ZC_WIDTH;
    localparam int unsigned NW    = gob_pkg::NUM_WIDTH;
    localparam int unsigned PW    = gob_pkg::PROD_WIDTH;

    logic                   busy_reg;
    logic [NW-1:0]          num_orient_reg;
    logic [NW-1:0]          num_orient_next;

    // capture stage
    logic                   cap_valid_reg;
    logic [GW-1:0]          cap_ax_reg;
    logic [GW-1:0]          cap_ay_reg;
    gob_pkg::meta_t         cap_meta_reg;
    logic [GW-1:0]          ax_next;
    logic [GW-1:0]          ay_next;
    gob_pkg::meta_t         meta_next;

    // leading-one search stage
    logic                   srch_valid_reg;
    logic [GW-1:0]          srch_ax_reg;
    logic [GW-1:0]          srch_ay_reg;
    logic [gob_pkg::SHIFT_WIDTH-1:0] srch_shift_reg;
    logic [gob_pkg::SHIFT_WIDTH-1:0] srch_shift_next;
    gob_pkg::meta_t         srch_meta_reg;
    logic [GW-1:0]          mag_max;
    logic [gob_pkg::MSB_WIDTH-1:0] mag_msb;

    // cordic pipeline, index 0 is the normalized vector
    logic [STEPS:0]         cor_valid_reg;
    logic signed [XYW-1:0]  cor_x_reg    [0:STEPS];
    logic signed [XYW-1:0]  cor_y_reg    [0:STEPS];
    logic signed [ZW-1:0]   cor_z_reg    [0:STEPS];
    gob_pkg::meta_t         cor_meta_reg [0:STEPS];

    // angle stage
    logic                   ang_valid_reg;
    logic [AB:0]            ang_phi_reg;
    logic [AB:0]            ang_phi_next;
    logic                   ang_zero_reg;
    logic [ZCW-1:0]         z_clamped;
    logic [ZCW-1:0]         z_rounded;
    logic [AB-1:0]          angle_raw;
    logic [AB-1:0]          angle_fix;
    gob_pkg::meta_t         last_meta;

    // multiply stage
    logic                   mul_valid_reg;
    logic [PW-1:0]          mul_prod_reg;
    logic [PW-1:0]          mul_prod_next;
    logic                   mul_zero_reg;

    // output stage
    logic                   done_reg;
    gob_pkg::result_t       result_reg;
    gob_pkg::result_t       result_next;
    logic [NW:0]            bin_full;

    assign busy   = busy_reg;
    assign done   = done_reg;
    assign result = result_reg;

    // config register
    always_comb
    begin
        if (cfg_wr_data == '0)
        begin
            num_orient_next = NW'(1);
        end
        else if (cfg_wr_data > gob_pkg::NUM_MAX_CODE)
        begin
            num_orient_next = gob_pkg::NUM_MAX_CODE;
        end
        else
        begin
            num_orient_next = cfg_wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg       <= 1'b1;
            num_orient_reg <= gob_pkg::NUM_RESET_CODE;
        end
        else
        begin
            busy_reg <= 1'b0;
            if (cfg_wr_en)
            begin
                num_orient_reg <= num_orient_next;
            end
        end
    end

    // capture: magnitudes and signs
    always_comb
    begin
        ax_next = pixel.grad_horizontal[GW-1] ? GW'(~pixel.grad_horizontal + 1'b1)
                                              : GW'(pixel.grad_horizontal);
        ay_next = pixel.grad_vertical[GW-1] ? GW'(~pixel.grad_vertical + 1'b1)
                                            : GW'(pixel.grad_vertical);
        meta_next.gx_neg  = pixel.grad_horizontal[GW-1];
        meta_next.gy_neg  = pixel.grad_vertical[GW-1];
        meta_next.ax_zero = (pixel.grad_horizontal == '0);
        meta_next.ay_zero = (pixel.grad_vertical == '0);
        meta_next.zero    = (pixel.grad_horizontal == '0) && (pixel.grad_vertical == '0);
    end

    // leading-one search over the larger magnitude
    always_comb
    begin
        mag_max = (cap_ax_reg > cap_ay_reg) ? cap_ax_reg : cap_ay_reg;
        mag_msb = '0;
        for (int j = 0; j < GW; j++)
        begin
            if (mag_max[j])
            begin
                mag_msb = gob_pkg::MSB_WIDTH'(j);
            end
        end
        srch_shift_next = gob_pkg::SHIFT_WIDTH'(gob_pkg::NORM_MSB)
                        - gob_pkg::SHIFT_WIDTH'(mag_msb);
    end

    // angle from the clamped and rounded cordic accumulator
    always_comb
    begin
        last_meta = cor_meta_reg[STEPS];
        if (cor_z_reg[STEPS] < 0)
        begin
            z_clamped = '0;
        end
        else if (cor_z_reg[STEPS] > gob_pkg::Z_RIGHT_ANGLE)
        begin
            z_clamped = ZCW'(gob_pkg::Z_RIGHT_ANGLE);
        end
        else
        begin
            z_clamped = cor_z_reg[STEPS][ZCW-1:0];
        end
        z_rounded = z_clamped + gob_pkg::ROUND_HALF;
        angle_raw = z_rounded[ZCW-1:gob_pkg::ROUND_SHIFT];
        if (last_meta.ax_zero)
        begin
            angle_fix = '0;
        end
        else if (last_meta.ay_zero || (angle_raw > gob_pkg::QUARTER_TURN))
        begin
            angle_fix = gob_pkg::QUARTER_TURN;
        end
        else
        begin
            angle_fix = angle_raw;
        end
        if (last_meta.gx_neg != last_meta.gy_neg)
        begin
            ang_phi_next = {1'b0, angle_fix};
        end
        else
        begin
            ang_phi_next = gob_pkg::HALF_TURN - {1'b0, angle_fix};
        end
    end

    // sector index
    assign mul_prod_next = ((PW'(num_orient_reg) * PW'(ang_phi_reg)) << 1)
                         + PW'(gob_pkg::HALF_TURN);
    assign bin_full      = mul_prod_reg[PW-1:AB+1];

    always_comb
    begin
        result_next.zero_gradient = mul_zero_reg;
        if (mul_zero_reg || (bin_full >= {1'b0, num_orient_reg}))
        begin
            result_next.orientation_bin = '0;
        end
        else
        begin
            result_next.orientation_bin = bin_full[gob_pkg::BIN_WIDTH-1:0];
        end
    end

    // valid chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_valid_reg  <= 1'b0;
            srch_valid_reg <= 1'b0;
            cor_valid_reg  <= '0;
            ang_valid_reg  <= 1'b0;
            mul_valid_reg  <= 1'b0;
            done_reg       <= 1'b0;
        end
        else
        begin
            cap_valid_reg        <= start && !busy_reg;
            srch_valid_reg       <= cap_valid_reg;
            cor_valid_reg[0]     <= srch_valid_reg;
            cor_valid_reg[STEPS:1] <= cor_valid_reg[STEPS-1:0];
            ang_valid_reg        <= cor_valid_reg[STEPS];
            mul_valid_reg        <= ang_valid_reg;
            done_reg             <= mul_valid_reg;
        end
    end

    // data path
    always_ff @(posedge clk)
    begin
        cap_ax_reg     <= ax_next;
        cap_ay_reg     <= ay_next;
        cap_meta_reg   <= meta_next;

        srch_ax_reg    <= cap_ax_reg;
        srch_ay_reg    <= cap_ay_reg;
        srch_shift_reg <= srch_shift_next;
        srch_meta_reg  <= cap_meta_reg;

        cor_x_reg[0]    <= XYW'(srch_ay_reg) << srch_shift_reg;
        cor_y_reg[0]    <= XYW'(srch_ax_reg) << srch_shift_reg;
        cor_z_reg[0]    <= '0;
        cor_meta_reg[0] <= srch_meta_reg;

        for (int i = 0; i < STEPS; i++)
        begin
            if (!cor_y_reg[i][XYW-1])
            begin
                cor_x_reg[i+1] <= cor_x_reg[i] + (cor_y_reg[i] >>> i);
                cor_y_reg[i+1] <= cor_y_reg[i] - (cor_x_reg[i] >>> i);
                cor_z_reg[i+1] <= cor_z_reg[i] + gob_pkg::atan_step(i);
            end
            else
            begin
                cor_x_reg[i+1] <= cor_x_reg[i] - (cor_y_reg[i] >>> i);
                cor_y_reg[i+1] <= cor_y_reg[i] + (cor_x_reg[i] >>> i);
                cor_z_reg[i+1] <= cor_z_reg[i] - gob_pkg::atan_step(i);
            end
            cor_meta_reg[i+1] <= cor_meta_reg[i];
        end

        ang_phi_reg  <= ang_phi_next;
        ang_zero_reg <= last_meta.zero;

        mul_prod_reg <= mul_prod_next;
        mul_zero_reg <= ang_zero_reg;

        result_reg   <= result_next;
    end

endmodule

@@ rtl/core/gob_checker.sv @@
// ----------------------------------------------------------------------------
// gob_checker
// Port-level checks of the gradient orientation binner: fixed latency and
// the results of the degenerate gradients.
// ----------------------------------------------------------------------------
module gob_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          start,
    input logic                          busy,
    input gob_pkg::pixel_t               pixel,
    input logic                          done,
    input gob_pkg::result_t              result
);

    localparam int unsigned LAT = gob_pkg::PIPE_LATENCY;

    // every request gives its result after the fixed latency
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LAT done)
    else $error("result missing after fixed latency");

    // no result without a request
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LAT))
    else $error("result without matching request");

    // zero gradient gives the flag and bin zero
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (pixel.grad_horizontal == '0) && (pixel.grad_vertical == '0))
        |-> ##LAT (done && result.zero_gradient && (result.orientation_bin == '0)))
    else $error("zero gradient not flagged");

    // vertical-only gradient lands in sector zero
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (pixel.grad_horizontal == '0) && (pixel.grad_vertical != '0))
        |-> ##LAT (done && !result.zero_gradient && (result.orientation_bin == '0)))
    else $error("vertical gradient not in sector zero");

    // once running the block never stalls requests
    assert property (@(posedge clk) disable iff (!rst_n)
        !busy |=> !busy)
    else $error("busy raised after reset");

endmodule

bind gradient_orientation_binner gob_checker u_gob_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .pixel  (pixel),
    .done   (done),
    .result (result)
);

@@ verif/tb_gradient_orientation_binner.sv @@
// ----------------------------------------------------------------------------
// tb_gradient_orientation_binner
// Self-checking testbench for the gradient orientation binner. A queue-fed
// driver sends pixel requests with random gaps and rewrites the sector count
// between phases. A monitor compares every result with a bit-exact CORDIC
// prediction made when the request was taken.
// ----------------------------------------------------------------------------
module tb_gradient_orientation_binner;

    timeunit 1ns;
    timeprecision 1ps;

    import gob_pkg::*;

    localparam int PHASES           = 10;
    localparam int RANDOM_PER_PHASE = 125;
    localparam int DIRECTED_COUNT   = 22;
    localparam int SETTLE_CYCLES    = 40;
    localparam int WATCHDOG_LIMIT   = 1000;
    localparam int MAX_REPORTS      = 10;

    localparam longint NORM_FLOOR = longint'(1) << 39;
    localparam longint RIGHT_ANGLE_PI31 = longint'(1) << 30;

    // atan(2^-i) in units of pi/2^31
    localparam longint ATAN_PI31 [0:25] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772,
        166886, 83443, 41722, 20861, 10430, 5215,
        2608, 1304, 652, 326, 163, 81,
        41, 20
    };

    typedef struct {
        bit                   is_cfg;
        logic [NUM_WIDTH-1:0] cfg_value;
        pixel_t               pix;
    } request_t;

    typedef struct {
        pixel_t  pix;
        result_t res;
    } expected_bin_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    pixel_t               pixel = '0;
    logic                 done;
    result_t              result;
    logic                 cfg_wr_en = 1'b0;
    logic [NUM_WIDTH-1:0] cfg_wr_data = '0;

    request_t             pending_requests [$];
    expected_bin_t        expected_bins [$];
    logic [NUM_WIDTH-1:0] num_setting = NUM_RESET_CODE;
    int                   gap_left = 0;
    int                   burst_left = 0;
    int                   idle_cycles = 0;
    int                   fail_count = 0;
    int                   accepted_count = 0;
    int                   result_count = 0;
    int                   zero_count = 0;
    int                   setting_count = 1;

    gradient_orientation_binner u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .pixel       (pixel),
        .done        (done),
        .result      (result),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic result_t predict_orientation(input pixel_t p,
                                                    input logic [NUM_WIDTH-1:0] setting);
        result_t r;
        longint  gx, gy, ax, ay, x, y, z, xs, ys, m, n, a, phi, sector;
        r  = '0;
        gx = $signed(p.grad_horizontal);
        gy = $signed(p.grad_vertical);
        n  = setting;
        if (n < 1)
            n = 1;
        if (n > NUM_MAX)
            n = NUM_MAX;
        if (gx == 0 && gy == 0)
        begin
            r.zero_gradient = 1'b1;
        end
        else
        begin
            ax = (gx < 0) ? -gx : gx;
            ay = (gy < 0) ? -gy : gy;
            if (ax == 0)
            begin
                a = 0;
            end
            else if (ay == 0)
            begin
                a = longint'(1) << (ANGLE_BITS - 1);
            end
            else
            begin
                x = ay;
                y = ax;
                z = 0;
                m = (x > y) ? x : y;
                while (m < NORM_FLOOR)
                begin
                    x = x << 1;
                    y = y << 1;
                    m = m << 1;
                end
                for (int i = 0; i < 26; i++)
                begin
                    xs = x >>> i;
                    ys = y >>> i;
                    if (y >= 0)
                    begin
                        x = x + ys;
                        y = y - xs;
                        z = z + ATAN_PI31[i];
                    end
                    else
                    begin
                        x = x - ys;
                        y = y + xs;
                        z = z - ATAN_PI31[i];
                    end
                end
                if (z < 0)
                    z = 0;
                if (z > RIGHT_ANGLE_PI31)
                    z = RIGHT_ANGLE_PI31;
                a = (z + (longint'(1) << (30 - ANGLE_BITS))) >>> (31 - ANGLE_BITS);
                if (a > (longint'(1) << (ANGLE_BITS - 1)))
                    a = longint'(1) << (ANGLE_BITS - 1);
            end
            if ((gx < 0) != (gy < 0))
                phi = a;
            else
                phi = (longint'(1) << ANGLE_BITS) - a;
            sector = (2 * n * phi + (longint'(1) << ANGLE_BITS)) >>> (ANGLE_BITS + 1);
            if (sector >= n)
                sector = 0;
            r.orientation_bin = BIN_WIDTH'(sector);
        end
        return r;
    endfunction

    function automatic logic signed [GRAD_WIDTH-1:0] extreme_grad();
        logic signed [GRAD_WIDTH-1:0] g;
        case ($urandom_range(0, 4))
            0:       g = {1'b1, {(GRAD_WIDTH-1){1'b0}}};
            1:       g = {1'b0, {(GRAD_WIDTH-1){1'b1}}};
            2:       g = '1;
            3:       g = GRAD_WIDTH'(1);
            default: g = '0;
        endcase
        return g;
    endfunction

    function automatic pixel_t random_pixel();
        pixel_t p;
        p.grad_horizontal = GRAD_WIDTH'($urandom);
        p.grad_vertical   = GRAD_WIDTH'($urandom);
        case ($urandom_range(0, 9))
            4:
            begin
                p.grad_horizontal = GRAD_WIDTH'(int'($urandom_range(0, 16)) - 8);
                p.grad_vertical   = GRAD_WIDTH'(int'($urandom_range(0, 16)) - 8);
            end
            5:
            begin
                if ($urandom_range(0, 1))
                    p.grad_horizontal = '0;
                else
                    p.grad_vertical = '0;
            end
            6:
            begin
                p.grad_vertical = $urandom_range(0, 1) ? p.grad_horizontal
                                                       : -p.grad_horizontal;
            end
            7:
            begin
                p.grad_horizontal = extreme_grad();
                p.grad_vertical   = extreme_grad();
            end
            8, 9:
            begin
                p.grad_horizontal = GRAD_WIDTH'(int'($urandom_range(0, 1023)) - 512);
                p.grad_vertical   = GRAD_WIDTH'(int'($urandom_range(0, 1023)) - 512);
            end
            default:
            begin
            end
        endcase
        return p;
    endfunction

    task automatic flag_error(input string msg);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $display("ERROR at %0t: %s", $realtime, msg);
    endtask

    task automatic wait_for_drain();
        while (pending_requests.size() != 0 || expected_bins.size() != 0 || start)
            @(posedge clk);
    endtask

    always @(posedge clk)
    begin : driver
        request_t             req;
        logic                 next_start;
        pixel_t               next_pixel;
        logic                 next_wr_en;
        logic [NUM_WIDTH-1:0] next_wr_data;
        next_start   = start;
        next_pixel   = pixel;
        next_wr_en   = 1'b0;
        next_wr_data = cfg_wr_data;
        if (rst_n)
        begin
            if (start && !busy)
            begin
                expected_bins.push_back('{pix: pixel,
                                          res: predict_orientation(pixel, num_setting)});
                accepted_count++;
                next_start = 1'b0;
            end
            if (!next_start)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                end
                else if (pending_requests.size() > 0)
                begin
                    req = pending_requests.pop_front();
                    if (req.is_cfg)
                    begin
                        next_wr_en   = 1'b1;
                        next_wr_data = req.cfg_value;
                        num_setting  = req.cfg_value;
                    end
                    else
                    begin
                        next_start = 1'b1;
                        next_pixel = req.pix;
                        if (burst_left == 0 && $urandom_range(0, 39) == 0)
                            burst_left = $urandom_range(10, 40);
                        if (burst_left > 0)
                        begin
                            burst_left--;
                            gap_left = 0;
                        end
                        else
                        begin
                            gap_left = $urandom_range(0, 12);
                        end
                    end
                end
            end
        end
        start       <= next_start;
        pixel       <= next_pixel;
        cfg_wr_en   <= next_wr_en;
        cfg_wr_data <= next_wr_data;
    end

    always @(posedge clk)
    begin : monitor
        expected_bin_t exp_bin;
        if (rst_n && done)
        begin
            result_count++;
            if (expected_bins.size() == 0)
            begin
                flag_error($sformatf("unexpected result bin=%0d zero=%0b",
                                     result.orientation_bin, result.zero_gradient));
            end
            else
            begin
                exp_bin = expected_bins.pop_front();
                if (exp_bin.res.zero_gradient)
                    zero_count++;
                if (result.orientation_bin !== exp_bin.res.orientation_bin ||
                    result.zero_gradient !== exp_bin.res.zero_gradient)
                    flag_error($sformatf(
                        "gx=%0d gy=%0d: expected bin=%0d zero=%0b, got bin=%0d zero=%0b",
                        exp_bin.pix.grad_horizontal, exp_bin.pix.grad_vertical,
                        exp_bin.res.orientation_bin, exp_bin.res.zero_gradient,
                        result.orientation_bin, result.zero_gradient));
            end
        end
    end

    always @(posedge clk)
    begin : watchdog
        if (!rst_n || (start && !busy) || done || cfg_wr_en)
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("timeout: no request or result for %0d cycles, %0d results pending",
                     idle_cycles, expected_bins.size());
            $display("CHECKS FAILED");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin : stimulus
        request_t req;
        int       plan [0:PHASES-1] = '{8, 1, 64, 0, 127, 2, 65, 13, 33, 0};
        int       dir_h [0:DIRECTED_COUNT-1] = '{
            0, 0, 0, 32767, -32768, 32767, -32768, -32768, 32767, 1, -1,
            1, -1, 0, 1, 0, -1, 1, 32767, -32768, -1, 3
        };
        int       dir_v [0:DIRECTED_COUNT-1] = '{
            0, 32767, -32768, 0, 0, 32767, -32768, 32767, -32768, 1, 1,
            -1, -1, 1, 0, -1, 0, 32767, 1, 1, -32768, -4
        };
        plan[PHASES-1] = $urandom_range(0, 127);
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        for (int k = 0; k < PHASES; k++)
        begin
            req = '{is_cfg: 1'b0, cfg_value: '0, pix: '0};
            if (k == 0)
            begin
                for (int d = 0; d < DIRECTED_COUNT; d++)
                begin
                    req.pix.grad_horizontal = GRAD_WIDTH'(dir_h[d]);
                    req.pix.grad_vertical   = GRAD_WIDTH'(dir_v[d]);
                    pending_requests.push_back(req);
                end
            end
            else
            begin
                // sector count only changes with nothing in flight
                wait_for_drain();
                req.is_cfg    = 1'b1;
                req.cfg_value = NUM_WIDTH'(plan[k]);
                pending_requests.push_back(req);
                req.is_cfg = 1'b0;
                setting_count++;
            end
            for (int r = 0; r < RANDOM_PER_PHASE; r++)
            begin
                req.pix = random_pixel();
                pending_requests.push_back(req);
            end
        end
        wait_for_drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (expected_bins.size() != 0)
            flag_error($sformatf("%0d results never arrived", expected_bins.size()));
        $display("checked %0d pixel requests and %0d results (%0d zero gradient)",
                 accepted_count, result_count, zero_count);
        $display("covered %0d sector-count settings including 0, 1, 64, 65 and 127",
                 setting_count);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
